// ----- src/fba_pkg.sv -----
package fba_pkg;

  localparam int WordW    = 16;
  localparam int WordBits = 4;
  localparam int MaxSpan  = 256;
  localparam int CountW   = 9;

  typedef enum logic [1:0] {
    OP_ALLOC    = 2'd0,
    OP_FIND_RUN = 2'd1,
    OP_MARK     = 2'd2,
    OP_CLEAR    = 2'd3
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] frame;
    logic [8:0] run_length;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [7:0] result_frame;
  } rsp_t;

  // Outcome of one word pass through the scan unit.
  typedef struct packed {
    logic                hit;
    logic [WordBits-1:0] idx;
    logic [CountW-1:0]   count;
  } scan_t;

  // Index of the highest set bit; zero for an empty word.
  function automatic logic [WordBits-1:0] fba_msb(input logic [WordW-1:0] v);
    logic [WordBits-1:0] r;
    r = '0;
    for (int k = 0; k < WordW; k++) begin
      if (v[k]) begin
        r = WordBits'(k);
      end
    end
    return r;
  endfunction

endpackage

// ----- src/fba_bitmap.sv -----
module fba_bitmap #(
  parameter int NWORDS = 16,
  parameter int AW     = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clr_i,
  input  logic                      set_en_i,
  input  logic [AW-1:0]             set_addr_i,
  input  logic [fba_pkg::WordBits-1:0] set_bit_i,
  input  logic [AW-1:0]             rd_addr_i,
  output logic [fba_pkg::WordW-1:0] rd_data_o
);
  import fba_pkg::*;

  logic [WordW-1:0] words_q [NWORDS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < NWORDS; w++) begin
        words_q[w] <= '0;
      end
    end else if (clr_i) begin
      for (int w = 0; w < NWORDS; w++) begin
        words_q[w] <= '0;
      end
    end else if (set_en_i) begin
      words_q[set_addr_i][set_bit_i] <= 1'b1;
    end
  end

  assign rd_data_o = words_q[rd_addr_i];

endmodule

// ----- src/fba_word_scan.sv -----
module fba_word_scan (
  input  logic [fba_pkg::WordW-1:0]  busy_i,
  input  logic                       is_run_i,
  input  logic [fba_pkg::CountW-1:0] count_i,
  input  logic [8:0]                 run_len_i,
  output fba_pkg::scan_t             scan_o
);
  import fba_pkg::*;

  always_comb begin
    logic [WordW-1:0] low;
    logic [WordW-1:0] m;
    logic [9:0]       cnt;
    logic             hit_j;
    scan_o = '0;
    // Walk from the top so the lowest qualifying bit wins.
    for (int j = WordW - 1; j >= 0; j--) begin
      low = {WordW{1'b1}} >> (WordW - 1 - j);
      m   = busy_i & low;
      // Length of the free run ending at bit j, carried in from earlier words.
      if (m == '0) begin
        cnt = 10'(count_i) + 10'(j + 1);
      end else begin
        cnt = 10'(j) - 10'(fba_msb(m));
      end
      if (is_run_i) begin
        hit_j = (cnt >= 10'(run_len_i));
      end else begin
        hit_j = !busy_i[j];
      end
      if (hit_j) begin
        scan_o.hit = 1'b1;
        scan_o.idx = WordBits'(j);
      end
      if (j == WordW - 1) begin
        scan_o.count = cnt[CountW-1:0];
      end
    end
  end

endmodule

// ----- src/frame_bitmap_allocator.sv -----
// Channel   | Direction | Handshake                    | Payload
// ----------+-----------+------------------------------+----------------------------
// request   | in        | start_i, accepted if !busy_o | req_i  (op, frame, run_length)
// result    | out       | rsp_valid_o, one-cycle pulse | rsp_o  (found, result_frame)
// config    | in        | cfg_valid_i / cfg_ready_o    | cfg_data_i (frames_in_use)
//
// Mark and clear requests never raise busy_o; the result pulses in the
// following cycle, so they can be issued back to back.
// Alloc and find-run walk the bitmap one 16-bit word per cycle through a
// shared scan unit, up to the word that holds the limit; a hit ends the walk
// early, and busy_o is high for the walk.
// Reset clears the bitmap at once (flip-flop storage) and sets the limit to 256.
// The receiver cannot stall: each result is shown for exactly one cycle.
module frame_bitmap_allocator #(
  parameter int NUM_FRAMES = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  fba_pkg::req_t req_i,
  output logic          rsp_valid_o,
  output fba_pkg::rsp_t rsp_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [8:0]    cfg_data_i
);
  import fba_pkg::*;

  // Only frames below 256 are ever reachable, so storage stops there.
  localparam int Span   = (NUM_FRAMES < MaxSpan) ? NUM_FRAMES : MaxSpan;
  localparam int NWords = (Span + WordW - 1) / WordW;
  localparam int AW     = (NWords > 1) ? $clog2(NWords) : 1;

  state_e            state_q, state_d;
  logic [AW-1:0]     word_q, word_d;
  logic [CountW-1:0] count_q, count_d;
  logic              is_run_q, is_run_d;
  logic [8:0]        runlen_q, runlen_d;
  rsp_t              rsp_q, rsp_d;
  logic              rsp_valid_q, rsp_valid_d;
  logic [8:0]        cfg_q;

  logic [8:0]          lim;
  logic [AW-1:0]       last_word;
  logic [8:0]          rem;
  logic [WordW-1:0]    valid_mask;
  logic [WordW-1:0]    rd_word;
  logic [WordW-1:0]    scan_busy;
  scan_t               scan;
  logic                clr;
  logic                set_en;
  logic [AW-1:0]       set_addr;
  logic [WordBits-1:0] set_bit;
  logic [8:0]          pos;
  logic [8:0]          run_start;

  // The limit register takes a write whenever offered.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= 9'(MaxSpan);
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= cfg_data_i;
    end
  end

  // Effective span and the last word a search has to visit.
  assign lim       = (cfg_q > 9'(Span)) ? 9'(Span) : cfg_q;
  assign last_word = AW'((lim - 9'd1) >> WordBits);

  // Treat frames at or above the limit as busy.
  assign rem        = lim - (9'(word_q) << WordBits);
  assign valid_mask = (rem >= 9'(WordW)) ? {WordW{1'b1}}
                                         : ((WordW'(1) << rem[WordBits-1:0]) - WordW'(1));
  assign scan_busy  = rd_word | ~valid_mask;

  fba_bitmap #(
    .NWORDS (NWords),
    .AW     (AW)
  ) u_bitmap (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (clr),
    .set_en_i   (set_en),
    .set_addr_i (set_addr),
    .set_bit_i  (set_bit),
    .rd_addr_i  (word_q),
    .rd_data_o  (rd_word)
  );

  fba_word_scan u_scan (
    .busy_i    (scan_busy),
    .is_run_i  (is_run_q),
    .count_i   (count_q),
    .run_len_i (runlen_q),
    .scan_o    (scan)
  );

  // Hit position and, for a run, its first frame.
  assign pos       = 9'({word_q, scan.idx});
  assign run_start = pos + 9'd1 - runlen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q   <= word_d;
    count_q  <= count_d;
    is_run_q <= is_run_d;
    runlen_q <= runlen_d;
    rsp_q    <= rsp_d;
  end

  always_comb begin
    state_d     = state_q;
    word_d      = word_q;
    count_d     = count_q;
    is_run_d    = is_run_q;
    runlen_d    = runlen_q;
    rsp_d       = rsp_q;
    rsp_valid_d = 1'b0;
    clr         = 1'b0;
    set_en      = 1'b0;
    set_addr    = word_q;
    set_bit     = scan.idx;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          rsp_d.result_frame = '0;
          unique case (req_i.op) inside
            OP_ALLOC, OP_FIND_RUN: begin
              is_run_d = (req_i.op == OP_FIND_RUN);
              runlen_d = req_i.run_length;
              word_d   = '0;
              count_d  = '0;
              // Fail at once on an empty span or a zero-length run.
              if (lim == '0 || (is_run_d && req_i.run_length == '0)) begin
                rsp_valid_d = 1'b1;
                rsp_d.found = 1'b0;
              end else begin
                state_d = ST_SCAN;
              end
            end
            OP_MARK: begin
              rsp_valid_d = 1'b1;
              rsp_d.found = 1'b0;
              if (9'(req_i.frame) < lim) begin
                set_en      = 1'b1;
                set_addr    = req_i.frame[WordBits +: AW];
                set_bit     = req_i.frame[WordBits-1:0];
                rsp_d.found = 1'b1;
              end
            end
            OP_CLEAR: begin
              clr         = 1'b1;
              rsp_valid_d = 1'b1;
              rsp_d.found = 1'b1;
            end
            default: begin
              rsp_valid_d = 1'b1;
              rsp_d.found = 1'b0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan.hit) begin
          // Claim the frame on alloc; find-run only reports.
          set_en             = !is_run_q;
          rsp_valid_d        = 1'b1;
          rsp_d.found        = 1'b1;
          rsp_d.result_frame = is_run_q ? run_start[7:0] : pos[7:0];
          state_d            = ST_IDLE;
        end else if (word_q == last_word) begin
          rsp_valid_d        = 1'b1;
          rsp_d.found        = 1'b0;
          rsp_d.result_frame = '0;
          state_d            = ST_IDLE;
        end else begin
          word_d  = word_q + AW'(1);
          count_d = scan.count;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o      = (state_q == ST_SCAN);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ----- src/fba_checker.sv -----
module fba_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input fba_pkg::req_t req_i,
  input logic          rsp_valid_o,
  input fba_pkg::rsp_t rsp_o
);
  import fba_pkg::*;

  // A walk only begins on an accepted request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without an accepted request");

  // A finished walk always delivers its result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> rsp_valid_o)
    else $error("walk ended without a result");

  // Clear always succeeds in the following cycle with frame zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_i.op == OP_CLEAR) |=>
      (rsp_valid_o && rsp_o.found && rsp_o.result_frame == '0))
    else $error("clear did not answer found");

  // A miss reports frame zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_o.found) |-> (rsp_o.result_frame == '0))
    else $error("miss with nonzero frame");

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (.*);
